// ===== hdl/dq_pkg.sv =====
// ---------------------------------------------------------------------------
// dq_pkg
// Shared types and codes for the double-ended queue: beat structs, command
// and status codes, cell operation codes.
// ---------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

  // default number of entries
  localparam int unsigned DefaultDepth = 16;

  // fixed field widths
  localparam int unsigned DataW     = 32;
  localparam int unsigned CmdW      = 2;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned ItemCountW = 5;

  // command codes
  localparam logic [CmdW-1:0] CmdPushFront = 2'd0;
  localparam logic [CmdW-1:0] CmdPushRear  = 2'd1;
  localparam logic [CmdW-1:0] CmdPopFront  = 2'd2;
  localparam logic [CmdW-1:0] CmdPopRear   = 2'd3;

  // status codes
  localparam logic [StatusW-1:0] StatusOk    = 2'd0;
  localparam logic [StatusW-1:0] StatusEmpty = 2'd1;
  localparam logic [StatusW-1:0] StatusFull  = 2'd2;

  // what one cell does at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_TAKE_LEFT,
    CELL_TAKE_RIGHT
  } cell_op_e;

  // input beat
  typedef struct packed {
    logic        [CmdW-1:0]  cmd;
    logic signed [DataW-1:0] value;
  } in_beat_t;

  // output beat
  typedef struct packed {
    logic signed [DataW-1:0]      popped_item;
    logic        [StatusW-1:0]    status;
    logic        [ItemCountW-1:0] item_count;
    logic signed [DataW-1:0]      front_item;
    logic signed [DataW-1:0]      rear_item;
    logic                         is_empty;
  } out_beat_t;

endpackage

`default_nettype wire

// ===== hdl/dq_cell.sv =====
// ---------------------------------------------------------------------------
// dq_cell
// One storage cell of the queue row. Holds one item, loads a new one, or
// takes the item of its left or right neighbor; drives its item onto the
// rear readout when selected.
// ---------------------------------------------------------------------------
`default_nettype none

module dq_cell (
  input  wire                                 clk_i,
  input  wire dq_pkg::cell_op_e               op_i,
  input  wire logic signed [dq_pkg::DataW-1:0] left_i,
  input  wire logic signed [dq_pkg::DataW-1:0] right_i,
  input  wire logic signed [dq_pkg::DataW-1:0] load_i,
  input  wire logic                            sel_i,
  output logic signed [dq_pkg::DataW-1:0]      data_o,
  output logic signed [dq_pkg::DataW-1:0]      tap_o
);

  logic signed [dq_pkg::DataW-1:0] data_q, data_d;

  // next item
  always_comb begin
    case (op_i)
      dq_pkg::CELL_LOAD:       data_d = load_i;
      dq_pkg::CELL_TAKE_LEFT:  data_d = left_i;
      dq_pkg::CELL_TAKE_RIGHT: data_d = right_i;
      default:                 data_d = data_q;
    endcase
  end

  // item storage
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // gated readout for the rear select
  assign data_o = data_q;
  assign tap_o  = sel_i ? data_q : '0;

endmodule

`default_nettype wire

// ===== hdl/double_ended_queue.sv =====
// ---------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit items held in a row of DEPTH cells.
//
// Input channel in_valid_i/in_ready_o carries a command (push front, push
// rear, pop front, pop rear) and an item. Output channel out_valid_o/
// out_ready_i returns one beat per command: the popped item, a status
// (ok, empty on pop, full on push), the count after the step, and the front
// and rear items after the step.
// The front item always sits in cell 0 and the rear in cell count-1. A push
// at the front shifts the whole row right, a pop at the front shifts it
// left, a rear push loads one cell and a rear pop only drops the count.
// The row updates at the accepting edge; the result is then formed from the
// updated row once the output register is free, and is registered there to
// drive out_valid_o. The input stays closed until the result is in that register.
// A new command is taken while an earlier result still waits on the output.
// If the receiver stalls, the result for the next command waits inside and
// in_ready_o stays low until the output register frees up.
// Reset empties the queue and clears both channels; cell contents are left
// as they are and are never read before being written.
// ---------------------------------------------------------------------------
`default_nettype none

module double_ended_queue #(
  parameter int unsigned DEPTH = dq_pkg::DefaultDepth
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  wire dq_pkg::in_beat_t   in_data_i,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  output dq_pkg::out_beat_t       out_data_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            busy_q, busy_d;
  logic            out_valid_q, out_valid_d;
  logic signed [dq_pkg::DataW-1:0]   pend_popped_q, pend_popped_d;
  logic        [dq_pkg::StatusW-1:0] pend_status_q, pend_status_d;
  dq_pkg::out_beat_t out_q, out_d;

  logic signed [dq_pkg::DataW-1:0] cell_data [DEPTH];
  logic signed [dq_pkg::DataW-1:0] cell_tap  [DEPTH];
  dq_pkg::cell_op_e                cell_op   [DEPTH];
  logic signed [dq_pkg::DataW-1:0] rear_data;
  logic [CntW-1:0]                 rear_pos;
  logic [CntW+dq_pkg::ItemCountW-1:0] count_ext;
  logic in_acc, is_full, is_empty;

  assign in_acc   = in_valid_i && in_ready_o;
  assign is_full  = (count_q == CntW'(DEPTH));
  assign is_empty = (count_q == '0);
  assign rear_pos = count_q - CntW'(1);

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [dq_pkg::DataW-1:0] left_w, right_w;

    if (i == 0) begin : g_first
      assign left_w = in_data_i.value;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end

    // per-cell operation for the accepted command
    always_comb begin
      cell_op[i] = dq_pkg::CELL_HOLD;
      if (in_acc) begin
        case (in_data_i.cmd)
          dq_pkg::CmdPushFront: begin
            if (!is_full) cell_op[i] = dq_pkg::CELL_TAKE_LEFT;
          end
          dq_pkg::CmdPushRear: begin
            if (!is_full && count_q == CntW'(i)) cell_op[i] = dq_pkg::CELL_LOAD;
          end
          dq_pkg::CmdPopFront: begin
            if (!is_empty) cell_op[i] = dq_pkg::CELL_TAKE_RIGHT;
          end
          default: cell_op[i] = dq_pkg::CELL_HOLD;
        endcase
      end
    end

    dq_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[i]),
      .left_i  (left_w),
      .right_i (right_w),
      .load_i  (in_data_i.value),
      .sel_i   (rear_pos == CntW'(i)),
      .data_o  (cell_data[i]),
      .tap_o   (cell_tap[i])
    );
  end

  // rear readout, zero when empty since no cell matches
  always_comb begin
    rear_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_data = rear_data | cell_tap[i];
    end
  end

  assign count_ext = {{dq_pkg::ItemCountW{1'b0}}, count_q};

  // command control and output register
  always_comb begin
    count_d       = count_q;
    busy_d        = busy_q;
    out_valid_d   = out_valid_q;
    out_d         = out_q;
    pend_popped_d = pend_popped_q;
    pend_status_d = pend_status_q;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    if (in_acc) begin
      busy_d        = 1'b1;
      pend_popped_d = '0;
      pend_status_d = dq_pkg::StatusOk;
      case (in_data_i.cmd)
        dq_pkg::CmdPushFront, dq_pkg::CmdPushRear: begin
          if (is_full) pend_status_d = dq_pkg::StatusFull;
          else count_d = count_q + CntW'(1);
        end
        dq_pkg::CmdPopFront: begin
          if (is_empty) pend_status_d = dq_pkg::StatusEmpty;
          else begin
            pend_popped_d = cell_data[0];
            count_d       = count_q - CntW'(1);
          end
        end
        default: begin
          if (is_empty) pend_status_d = dq_pkg::StatusEmpty;
          else begin
            pend_popped_d = rear_data;
            count_d       = count_q - CntW'(1);
          end
        end
      endcase
    end else if (busy_q && (!out_valid_q || out_ready_i)) begin
      busy_d                 = 1'b0;
      out_valid_d            = 1'b1;
      out_d.popped_item      = pend_popped_q;
      out_d.status           = pend_status_q;
      out_d.item_count       = count_ext[dq_pkg::ItemCountW-1:0];
      out_d.front_item       = is_empty ? '0 : cell_data[0];
      out_d.rear_item        = rear_data;
      out_d.is_empty         = is_empty;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q         <= out_d;
    pend_popped_q <= pend_popped_d;
    pend_status_q <= pend_status_d;
  end

  assign in_ready_o  = !busy_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== hdl/dq_checker.sv =====
// ---------------------------------------------------------------------------
// dq_checker
// Port-level checks for the double-ended queue, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module dq_checker #(
  parameter int unsigned DEPTH = dq_pkg::DefaultDepth
) (
  input wire                    clk_i,
  input wire                    rst_ni,
  input wire                    in_valid_i,
  input wire                    in_ready_o,
  input wire                    out_valid_o,
  input wire                    out_ready_i,
  input wire dq_pkg::out_beat_t out_data_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1) + dq_pkg::ItemCountW;

  logic [CntW-1:0] cnt_ext;
  assign cnt_ext = {{($clog2(DEPTH + 1)){1'b0}}, out_data_o.item_count};

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat dropped or changed while stalled");

  // one command in flight: input closes after an accepted beat
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second command taken while first still in flight");

  // empty flag agrees with count and the end items
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_empty |->
      out_data_o.item_count == '0 && out_data_o.front_item == '0 &&
      out_data_o.rear_item == '0)
    else $error("empty flag disagrees with count or end items");

  // refused push only at full
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == dq_pkg::StatusFull |->
      cnt_ext == CntW'(DEPTH))
    else $error("full reported below capacity");

  // refused pop only when empty, nothing popped
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == dq_pkg::StatusEmpty |->
      out_data_o.is_empty && out_data_o.popped_item == '0)
    else $error("empty pop reported with items held");

endmodule

bind double_ended_queue dq_checker #(.DEPTH(DEPTH)) u_dq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for double_ended_queue. A driver feeds command beats
// from a pending queue, a shadow deque predicts each result beat on input
// acceptance, and a monitor compares every output beat field by field.
// Runs directed corner cases, then biased random push/pop bursts under
// several sender/receiver idle mixes and one long receiver hold-off.
// ---------------------------------------------------------------------------
module tb_top;
  import dq_pkg::*;

  localparam int unsigned Depth     = DefaultDepth;
  localparam int unsigned IdxW      = $clog2(Depth);
  localparam int unsigned HoldLen   = 300;
  localparam int unsigned CycleLimit = 200000;

  typedef enum logic [2:0] {
    MODE_FREE,
    MODE_SEND_IDLE,
    MODE_RECV_STALL,
    MODE_BOTH_IDLE,
    MODE_HOLD
  } idle_mode_e;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid    = 1'b0;
  in_beat_t  in_data     = '0;
  logic      out_ready   = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_beat_t out_data;

  idle_mode_e  idle_mode   = MODE_FREE;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_cnt;
  int unsigned cycle_cnt   = 0;
  int unsigned err_cnt     = 0;
  int unsigned beats_seen  = 0;
  int unsigned push_cnt    = 0;
  int unsigned pop_cnt     = 0;
  int unsigned full_cnt    = 0;
  int unsigned empty_cnt   = 0;

  in_beat_t  cmd_backlog[$];
  out_beat_t expected_beats[$];

  // shadow deque
  logic signed [DataW-1:0] shadow_ring [Depth];
  logic [IdxW-1:0]         shadow_head = '0;
  logic [ItemCountW-1:0]   shadow_fill = '0;

  double_ended_queue #(
    .DEPTH(Depth)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // idle percentages per mode
  always_comb begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    case (idle_mode)
      MODE_SEND_IDLE:  send_idle_pct  = 69;
      MODE_RECV_STALL: recv_stall_pct = 69;
      MODE_BOTH_IDLE: begin
        send_idle_pct  = 7;
        recv_stall_pct = 7;
      end
      default: ;
    endcase
  end

  // apply one command to the shadow deque and form its result beat
  function automatic out_beat_t deque_step(input in_beat_t beat);
    out_beat_t res;
    res        = '0;
    res.status = StatusOk;
    case (beat.cmd)
      CmdPushFront: begin
        if (shadow_fill == Depth) begin
          res.status = StatusFull;
        end else begin
          shadow_head              = IdxW'((shadow_head + Depth - 1) % Depth);
          shadow_ring[shadow_head] = beat.value;
          shadow_fill              = shadow_fill + 1'b1;
        end
      end
      CmdPushRear: begin
        if (shadow_fill == Depth) begin
          res.status = StatusFull;
        end else begin
          shadow_ring[IdxW'((shadow_head + shadow_fill) % Depth)] = beat.value;
          shadow_fill = shadow_fill + 1'b1;
        end
      end
      CmdPopFront: begin
        if (shadow_fill == 0) begin
          res.status = StatusEmpty;
        end else begin
          res.popped_item = shadow_ring[shadow_head];
          shadow_head     = IdxW'((shadow_head + 1) % Depth);
          shadow_fill     = shadow_fill - 1'b1;
        end
      end
      CmdPopRear: begin
        if (shadow_fill == 0) begin
          res.status = StatusEmpty;
        end else begin
          res.popped_item =
            shadow_ring[IdxW'((shadow_head + shadow_fill - 1) % Depth)];
          shadow_fill     = shadow_fill - 1'b1;
        end
      end
      default: ;
    endcase
    res.item_count = shadow_fill;
    res.is_empty   = (shadow_fill == 0);
    if (shadow_fill != 0) begin
      res.front_item = shadow_ring[shadow_head];
      res.rear_item  = shadow_ring[IdxW'((shadow_head + shadow_fill - 1) % Depth)];
    end
    return res;
  endfunction

  function automatic void check_field(input string name, input longint exp_v,
                                      input longint got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      err_cnt++;
    end
  endfunction

  // driver: predict on acceptance, then offer the next beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        out_beat_t exp_beat;
        exp_beat = deque_step(in_data);
        expected_beats.push_back(exp_beat);
        if (exp_beat.status == StatusFull) full_cnt++;
        else if (exp_beat.status == StatusEmpty) empty_cnt++;
        else if (in_data.cmd == CmdPushFront || in_data.cmd == CmdPushRear) push_cnt++;
        else pop_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= cmd_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off in the hold phase
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      hold_cnt  <= 0;
    end else if (idle_mode == MODE_HOLD && hold_cnt < HoldLen) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat: popped_item %0d status %0d",
               out_data.popped_item, out_data.status);
        err_cnt++;
      end else begin
        out_beat_t exp_beat;
        exp_beat = expected_beats.pop_front();
        check_field("popped_item", exp_beat.popped_item, out_data.popped_item);
        check_field("status",      exp_beat.status,      out_data.status);
        check_field("item_count",  exp_beat.item_count,  out_data.item_count);
        check_field("front_item",  exp_beat.front_item,  out_data.front_item);
        check_field("rear_item",   exp_beat.rear_item,   out_data.rear_item);
        check_field("is_empty",    exp_beat.is_empty,    out_data.is_empty);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout: %0d results still outstanding", expected_beats.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic add_cmd(input logic [CmdW-1:0] cmd, input logic [DataW-1:0] value);
    in_beat_t beat;
    beat.cmd   = cmd;
    beat.value = value;
    cmd_backlog.push_back(beat);
  endtask

  // random value, with the extremes mixed in now and then
  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(19))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // push-leaning, pop-leaning or balanced bursts so the deque swings between empty and full
  task automatic add_random(input int unsigned n);
    int unsigned push_pct;
    int unsigned run_left;
    logic [CmdW-1:0] cmd;
    run_left = 0;
    push_pct = 50;
    repeat (n) begin
      if (run_left == 0) begin
        run_left = $urandom_range(40, 8);
        case ($urandom_range(2))
          0:       push_pct = 80;
          1:       push_pct = 20;
          default: push_pct = 50;
        endcase
      end
      run_left--;
      if ($urandom_range(99) < push_pct) begin
        cmd = $urandom_range(1) ? CmdPushRear : CmdPushFront;
      end else begin
        cmd = $urandom_range(1) ? CmdPopRear : CmdPopFront;
      end
      add_cmd(cmd, pick_value());
    end
  endtask

  task automatic drain();
    while (cmd_backlog.size() != 0 || in_valid || expected_beats.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // stimulus
  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty pops, extremes, fill to full, full pushes
    add_cmd(CmdPopFront, $urandom);
    add_cmd(CmdPopRear, $urandom);
    add_cmd(CmdPushFront, 32'h8000_0000);
    add_cmd(CmdPopRear, $urandom);
    add_cmd(CmdPushRear, 32'h7fff_ffff);
    add_cmd(CmdPushFront, 32'hffff_ffff);
    add_cmd(CmdPushRear, 32'h0000_0000);
    add_cmd(CmdPopFront, 32'h5555_aaaa);
    for (int i = 0; i < Depth - 2; i++) begin
      add_cmd(i[0] ? CmdPushRear : CmdPushFront, {i[3:0], 28'h0} ^ $urandom);
    end
    add_cmd(CmdPushFront, 32'h1234_5678);
    add_cmd(CmdPushRear, 32'h8765_4321);
    add_cmd(CmdPopFront, $urandom);
    add_cmd(CmdPopRear, $urandom);
    drain();

    // random phases under different idle mixes
    idle_mode = MODE_FREE;
    add_random(400);
    drain();
    idle_mode = MODE_SEND_IDLE;
    add_random(320);
    drain();
    idle_mode = MODE_RECV_STALL;
    add_random(320);
    drain();
    idle_mode = MODE_BOTH_IDLE;
    add_random(320);
    drain();

    // long receiver hold-off while the sender keeps offering
    idle_mode = MODE_HOLD;
    add_random(80);
    drain();

    repeat (20) @(negedge clk_i);
    $display("covered %0d result beats: %0d pushes, %0d pops, %0d full, %0d empty",
             beats_seen, push_cnt, pop_cnt, full_cnt, empty_cnt);
    $display("idle mixes: none, sender, receiver, both, plus a %0d-cycle output hold",
             HoldLen);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/dq_pkg.sv
hdl/dq_cell.sv
hdl/double_ended_queue.sv
hdl/dq_checker.sv
sim/tb_top.sv
